[rtl/ptc_pkg.sv]
package ptc_pkg;

    localparam int RAW_W      = 20;
    localparam int CAL_W      = 48;
    localparam int NUM_CAL    = 4;
    localparam int CAL_IDX_W  = 2;

    // register indexes
    localparam logic [CAL_IDX_W-1:0] CAL_TEMP    = 2'd0;
    localparam logic [CAL_IDX_W-1:0] CAL_PRESS_A = 2'd1;
    localparam logic [CAL_IDX_W-1:0] CAL_PRESS_B = 2'd2;
    localparam logic [CAL_IDX_W-1:0] CAL_PRESS_C = 2'd3;

    localparam logic [32:0] FINE_OFFSET = 33'd128000;
    localparam logic [20:0] PRESS_BASE  = 21'd1048576;
    localparam logic [11:0] DIV_SCALE   = 12'd3125;
    localparam logic [63:0] ONE_Q47     = 64'h0000_8000_0000_0000;
    localparam logic [31:0] PRESS_MAX   = 32'hFFFF_FFFF;

    // front stages, divider steps, back stages
    localparam int FRONT_STG = 14;
    localparam int DIV_STG   = 64;
    localparam int BACK_STG  = 7;
    localparam int NUM_STG   = FRONT_STG + DIV_STG + BACK_STG;

endpackage

[rtl/ptc_in_if.sv]
interface ptc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ptc_pkg::RAW_W-1:0]   raw_temp;
    logic [ptc_pkg::RAW_W-1:0]   raw_press;

    modport source (output valid, raw_temp, raw_press, input ready);
    modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

[rtl/ptc_out_if.sv]
interface ptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic               sample_ok;

    modport source (output valid, temp_centi, press_q24_8, sample_ok, input ready);
    modport sink   (input valid, temp_centi, press_q24_8, sample_ok, output ready);
endinterface

[rtl/pressure_temperature_compensation.sv]
// channel   | dir | handshake     | payload
// i_in      | in  | valid / ready | raw_temp[19:0], raw_press[19:0]
// o_out     | out | valid / ready | temp_centi[31:0], press_q24_8[31:0], sample_ok
// i_cfg_*   | in  | write enable  | i_cfg_idx[1:0], i_cfg_data[47:0]
//
// One request enters per cycle unless the output stalls; each result passes through 14 arithmetic
// stages, a 64-step restoring divider with one quotient bit per stage, and 7 back stages.
// Reset (synchronous, active low) clears the calibration registers and all valid bits.
// The whole pipeline advances together; it holds when the output register is full
// and not taken, so a stall drops and repeats nothing.
module pressure_temperature_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptc_in_if.sink                        i_in,
    ptc_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CAL_IDX_W-1:0] i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]     i_cfg_data
);
    import ptc_pkg::*;

    logic [CAL_W-1:0] r_cal [NUM_CAL];
    logic [NUM_STG-1:0] r_vld;
    logic en;

    // calibration fields
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0]        p6x, p3x, p9x, p8x;

    assign t1 = r_cal[CAL_TEMP][15:0];
    assign t2 = r_cal[CAL_TEMP][31:16];
    assign t3 = r_cal[CAL_TEMP][47:32];
    assign p1 = r_cal[CAL_PRESS_A][15:0];
    assign p2 = r_cal[CAL_PRESS_A][31:16];
    assign p3 = r_cal[CAL_PRESS_A][47:32];
    assign p4 = r_cal[CAL_PRESS_B][15:0];
    assign p5 = r_cal[CAL_PRESS_B][31:16];
    assign p6 = r_cal[CAL_PRESS_B][47:32];
    assign p7 = r_cal[CAL_PRESS_C][15:0];
    assign p8 = r_cal[CAL_PRESS_C][31:16];
    assign p9 = r_cal[CAL_PRESS_C][47:32];
    assign p6x = {{16{p6[15]}}, p6};
    assign p3x = {{16{p3[15]}}, p3};
    assign p9x = {{16{p9[15]}}, p9};
    assign p8x = {{16{p8[15]}}, p8};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CAL; k++) r_cal[k] <= '0;
        end else if (i_cfg_we) begin
            r_cal[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign en = !r_vld[NUM_STG-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STG-2:0], i_in.valid};
        end
    end

    // ---------------- stage registers ----------------
    logic signed [17:0] r_a_ta;
    logic signed [16:0] r_a_td;
    logic [19:0]        r_a_ap, r_b_ap, r_c_ap, r_d_ap, r_e_ap, r_f_ap, r_g_ap, r_h_ap,
                        r_i_ap, r_j_ap;
    logic [31:0]        r_b_ma, r_b_dd, r_c_a, r_c_dm, r_d_fine;
    logic signed [32:0] r_e_v1;
    logic [31:0]        r_e_temp, r_f_temp, r_g_temp, r_h_temp, r_i_temp, r_j_temp,
                        r_k_temp, r_l_temp, r_m_temp, r_n_temp;
    logic [63:0]        r_f_lolo, r_f_corr, r_g_sq;
    logic signed [48:0] r_f_v1p5, r_f_v1p2, r_g_v1p5, r_g_v1p2, r_h_v1p5, r_h_v1p2,
                        r_i_v1p5, r_i_v1p2;
    logic signed [48:0] r_h_s6lo, r_h_s3lo;
    logic [31:0]        r_h_s6hi, r_h_s3hi;
    logic [63:0]        r_i_sq6, r_i_sq3, r_j_v2, r_j_x, r_k_y, r_k_n;
    logic [47:0]        r_l_ylo;
    logic [43:0]        r_l_nlo;
    logic [31:0]        r_l_yhi, r_l_nhi;
    logic [30:0]        r_m_dv;
    logic [63:0]        r_m_num, r_n_ma;
    logic [30:0]        r_n_md;
    logic               r_n_neg, r_n_zero;

    // divider steps
    logic [30:0] r_dv_rem  [DIV_STG];
    logic [63:0] r_dv_q    [DIV_STG];
    logic [30:0] r_dv_md   [DIV_STG];
    logic        r_dv_neg  [DIV_STG];
    logic        r_dv_zero [DIV_STG];
    logic [31:0] r_dv_temp [DIV_STG];
    logic [30:0] n_dv_rem  [DIV_STG];
    logic [63:0] n_dv_q    [DIV_STG];

    // back stages
    logic [63:0]        r_p1_p, r_p2_p, r_p3_p, r_p4_p, r_p5_p, r_p2_s, r_p3_s;
    logic signed [48:0] r_p2_p9lo, r_p2_p8lo;
    logic [31:0]        r_p2_p9hi, r_p2_p8hi;
    logic [63:0]        r_p3_t, r_p3_v2, r_p4_v2, r_p5_v2, r_p4_ll, r_p5_v1, r_p6_w;
    logic [31:0]        r_p4_lh, r_p4_hl;
    logic               r_p1_zero, r_p2_zero, r_p3_zero, r_p4_zero, r_p5_zero, r_p6_zero;
    logic [31:0]        r_p1_temp, r_p2_temp, r_p3_temp, r_p4_temp, r_p5_temp, r_p6_temp;
    logic [31:0]        r_o_temp, r_o_press;
    logic               r_o_ok;

    // ---------------- combinational stage logic ----------------
    logic signed [33:0] n_pm, n_pd;
    logic signed [19:0] n_dsh;
    logic signed [35:0] n_pt;
    logic [31:0]        n_f5;
    logic [20:0]        n_pr;
    logic [63:0]        n_z, n_p1, n_s, n_p8, n_u, n_sum, n_w;
    logic [31:0]        n_press;

    assign n_pm  = r_a_ta * t2;
    assign n_pd  = r_a_td * r_a_td;
    assign n_dsh = n_dsh_calc(r_b_dd);
    assign n_pt  = n_dsh * t3;
    assign n_f5  = r_d_fine + {r_d_fine[29:0], 2'b00} + 32'd128;
    assign n_pr  = PRESS_BASE - {1'b0, r_j_ap};
    assign n_z   = {16'b0, r_l_ylo} + {r_l_yhi, 32'b0};
    assign n_p1  = r_n_neg_q(r_dv_neg[DIV_STG-1], r_dv_q[DIV_STG-1]);
    assign n_s   = {{13{r_p1_p[63]}}, r_p1_p[63:13]};
    assign n_p8  = {{15{r_p2_p8lo[48]}}, r_p2_p8lo} + {r_p2_p8hi, 32'b0};
    assign n_u   = r_p4_ll + {r_p4_lh + r_p4_hl, 32'b0};
    assign n_sum = r_p5_p + r_p5_v1 + r_p5_v2;
    assign n_w   = 64'($signed(n_sum) >>> 8) + {{44{p7[15]}}, p7, 4'b0000};

    function automatic logic signed [19:0] n_dsh_calc(input logic [31:0] dd);
        logic [31:0] sh;
        sh = $signed(dd) >>> 12;
        return sh[19:0];
    endfunction

    function automatic logic [63:0] r_n_neg_q(input logic neg, input logic [63:0] q);
        return neg ? (64'd0 - q) : q;
    endfunction

    always_comb begin
        if (r_p6_zero || r_p6_w[63]) begin
            n_press = '0;
        end else if (|r_p6_w[63:32]) begin
            n_press = PRESS_MAX;
        end else begin
            n_press = r_p6_w[31:0];
        end
    end

    // one restoring step per stage
    always_comb begin
        logic [31:0] trial;
        logic        ge;
        for (int k = 0; k < DIV_STG; k++) begin
            if (k == 0) begin
                trial = {r_n_ma[63:32] == 32'd0 ? 31'd0 : 31'd0, r_n_ma[63]};
                ge    = trial >= {1'b0, r_n_md};
                n_dv_rem[k] = ge ? 31'(trial - {1'b0, r_n_md}) : trial[30:0];
                n_dv_q[k]   = {r_n_ma[62:0], ge};
            end else begin
                trial = {r_dv_rem[k-1], r_dv_q[k-1][63]};
                ge    = trial >= {1'b0, r_dv_md[k-1]};
                n_dv_rem[k] = ge ? 31'(trial - {1'b0, r_dv_md[k-1]}) : trial[30:0];
                n_dv_q[k]   = {r_dv_q[k-1][62:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // A: offsets of the raw temperature
            r_a_ta <= {1'b0, i_in.raw_temp[19:3]} - {1'b0, t1, 1'b0};
            r_a_td <= {1'b0, i_in.raw_temp[19:4]} - {1'b0, t1};
            r_a_ap <= i_in.raw_press;
            // B
            r_b_ma <= n_pm[31:0];
            r_b_dd <= n_pd[31:0];
            r_b_ap <= r_a_ap;
            // C
            r_c_a  <= $signed(r_b_ma) >>> 11;
            r_c_dm <= n_pt[31:0];
            r_c_ap <= r_b_ap;
            // D: fine temperature
            r_d_fine <= r_c_a + 32'($signed(r_c_dm) >>> 14);
            r_d_ap   <= r_c_ap;
            // E
            r_e_v1   <= $signed({r_d_fine[31], r_d_fine} - FINE_OFFSET);
            r_e_temp <= $signed(n_f5) >>> 8;
            r_e_ap   <= r_d_ap;
            // F: square of v1 modulo 2^64 from its low word and sign
            r_f_lolo <= r_e_v1[31:0] * r_e_v1[31:0];
            r_f_corr <= r_e_v1[32] ? {r_e_v1[30:0], 33'b0} : 64'd0;
            r_f_v1p5 <= r_e_v1 * p5;
            r_f_v1p2 <= r_e_v1 * p2;
            r_f_temp <= r_e_temp;
            r_f_ap   <= r_e_ap;
            // G
            r_g_sq   <= r_f_lolo - r_f_corr;
            r_g_v1p5 <= r_f_v1p5;
            r_g_v1p2 <= r_f_v1p2;
            r_g_temp <= r_f_temp;
            r_g_ap   <= r_f_ap;
            // H
            r_h_s6lo <= p6 * $signed({1'b0, r_g_sq[31:0]});
            r_h_s6hi <= r_g_sq[63:32] * p6x;
            r_h_s3lo <= p3 * $signed({1'b0, r_g_sq[31:0]});
            r_h_s3hi <= r_g_sq[63:32] * p3x;
            r_h_v1p5 <= r_g_v1p5;
            r_h_v1p2 <= r_g_v1p2;
            r_h_temp <= r_g_temp;
            r_h_ap   <= r_g_ap;
            // I
            r_i_sq6  <= {{15{r_h_s6lo[48]}}, r_h_s6lo} + {r_h_s6hi, 32'b0};
            r_i_sq3  <= {{15{r_h_s3lo[48]}}, r_h_s3lo} + {r_h_s3hi, 32'b0};
            r_i_v1p5 <= r_h_v1p5;
            r_i_v1p2 <= r_h_v1p2;
            r_i_temp <= r_h_temp;
            r_i_ap   <= r_h_ap;
            // J
            r_j_v2   <= r_i_sq6 + {r_i_v1p5[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
            r_j_x    <= 64'($signed(r_i_sq3) >>> 8) + {{3{r_i_v1p2[48]}}, r_i_v1p2, 12'b0};
            r_j_temp <= r_i_temp;
            r_j_ap   <= r_i_ap;
            // K
            r_k_y    <= ONE_Q47 + r_j_x;
            r_k_n    <= {12'b0, n_pr, 31'b0} - r_j_v2;
            r_k_temp <= r_j_temp;
            // L
            r_l_ylo  <= r_k_y[31:0] * p1;
            r_l_yhi  <= r_k_y[63:32] * {16'b0, p1};
            r_l_nlo  <= r_k_n[31:0] * DIV_SCALE;
            r_l_nhi  <= r_k_n[63:32] * {20'b0, DIV_SCALE};
            r_l_temp <= r_k_temp;
            // M: divisor and dividend
            r_m_dv   <= n_z[63:33];
            r_m_num  <= {20'b0, r_l_nlo} + {r_l_nhi, 32'b0};
            r_m_temp <= r_l_temp;
            // N: magnitudes and quotient sign
            r_n_ma   <= r_m_num[63] ? (64'd0 - r_m_num) : r_m_num;
            r_n_md   <= r_m_dv[30] ? (31'd0 - r_m_dv) : r_m_dv;
            r_n_neg  <= r_m_num[63] ^ r_m_dv[30];
            r_n_zero <= (r_m_dv == 31'd0);
            r_n_temp <= r_m_temp;
            // divider
            for (int k = 0; k < DIV_STG; k++) begin
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_q[k]   <= n_dv_q[k];
                if (k == 0) begin
                    r_dv_md[k]   <= r_n_md;
                    r_dv_neg[k]  <= r_n_neg;
                    r_dv_zero[k] <= r_n_zero;
                    r_dv_temp[k] <= r_n_temp;
                end else begin
                    r_dv_md[k]   <= r_dv_md[k-1];
                    r_dv_neg[k]  <= r_dv_neg[k-1];
                    r_dv_zero[k] <= r_dv_zero[k-1];
                    r_dv_temp[k] <= r_dv_temp[k-1];
                end
            end
            // P1: signed quotient
            r_p1_p    <= n_p1;
            r_p1_zero <= r_dv_zero[DIV_STG-1];
            r_p1_temp <= r_dv_temp[DIV_STG-1];
            // P2
            r_p2_s    <= n_s;
            r_p2_p    <= r_p1_p;
            r_p2_p9lo <= p9 * $signed({1'b0, n_s[31:0]});
            r_p2_p9hi <= n_s[63:32] * p9x;
            r_p2_p8lo <= p8 * $signed({1'b0, r_p1_p[31:0]});
            r_p2_p8hi <= r_p1_p[63:32] * p8x;
            r_p2_zero <= r_p1_zero;
            r_p2_temp <= r_p1_temp;
            // P3
            r_p3_t    <= {{15{r_p2_p9lo[48]}}, r_p2_p9lo} + {r_p2_p9hi, 32'b0};
            r_p3_v2   <= $signed(n_p8) >>> 19;
            r_p3_s    <= r_p2_s;
            r_p3_p    <= r_p2_p;
            r_p3_zero <= r_p2_zero;
            r_p3_temp <= r_p2_temp;
            // P4: t * s modulo 2^64
            r_p4_ll   <= r_p3_t[31:0] * r_p3_s[31:0];
            r_p4_lh   <= r_p3_t[31:0] * r_p3_s[63:32];
            r_p4_hl   <= r_p3_t[63:32] * r_p3_s[31:0];
            r_p4_p    <= r_p3_p;
            r_p4_v2   <= r_p3_v2;
            r_p4_zero <= r_p3_zero;
            r_p4_temp <= r_p3_temp;
            // P5
            r_p5_v1   <= $signed(n_u) >>> 25;
            r_p5_p    <= r_p4_p;
            r_p5_v2   <= r_p4_v2;
            r_p5_zero <= r_p4_zero;
            r_p5_temp <= r_p4_temp;
            // P6
            r_p6_w    <= n_w;
            r_p6_zero <= r_p5_zero;
            r_p6_temp <= r_p5_temp;
            // P7: clamp into the output register
            r_o_press <= n_press;
            r_o_ok    <= (n_press != 32'd0);
            r_o_temp  <= r_p6_temp;
        end
    end

    assign o_out.valid       = r_vld[NUM_STG-1];
    assign o_out.temp_centi  = r_o_temp;
    assign o_out.press_q24_8 = r_o_press;
    assign o_out.sample_ok   = r_o_ok;

endmodule

[bench/ptc_checker.sv]
`timescale 1ns / 100ps

module ptc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptc_in_if                             in_ch,
    ptc_out_if                            out_ch,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CAL_IDX_W-1:0] i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ptc_pkg::*;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic               sample_ok;
    } comp_result_t;

    logic [CAL_W-1:0] cal_q [NUM_CAL];
    comp_result_t     comp_expect [$];

    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    // truncating signed divide on 64-bit patterns; most negative / -1 wraps
    function automatic logic [63:0] sdiv64(logic [63:0] a, logic [63:0] d);
        logic [63:0] ma, md, q;
        ma = a[63] ? -a : a;
        md = d[63] ? -d : d;
        q  = ma / md;
        return (a[63] != d[63]) ? -q : q;
    endfunction

    function automatic comp_result_t compensate(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
        comp_result_t r;
        logic [31:0] adc_t, t1, t2, t3, x, a, d, fine, temp;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, w, press;
        adc_t = {12'd0, raw_t};
        t1 = {16'd0, cal_q[CAL_TEMP][15:0]};
        t2 = 32'(sx16(cal_q[CAL_TEMP][31:16]));
        t3 = 32'(sx16(cal_q[CAL_TEMP][47:32]));
        p1 = {48'd0, cal_q[CAL_PRESS_A][15:0]};
        p2 = sx16(cal_q[CAL_PRESS_A][31:16]);
        p3 = sx16(cal_q[CAL_PRESS_A][47:32]);
        p4 = sx16(cal_q[CAL_PRESS_B][15:0]);
        p5 = sx16(cal_q[CAL_PRESS_B][31:16]);
        p6 = sx16(cal_q[CAL_PRESS_B][47:32]);
        p7 = sx16(cal_q[CAL_PRESS_C][15:0]);
        p8 = sx16(cal_q[CAL_PRESS_C][31:16]);
        p9 = sx16(cal_q[CAL_PRESS_C][47:32]);

        x = (adc_t >> 3) - (t1 << 1);
        x = x * t2;
        a = asr32(x, 11);
        d = (adc_t >> 4) - t1;
        x = d * d;
        x = asr32(x, 12) * t3;
        d = asr32(x, 14);
        fine = a + d;
        x = fine * 32'd5 + 32'd128;
        temp = asr32(x, 8);

        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        w  = v1 * p5;
        v2 = v2 + (w << 17) + (p4 << 35);
        w  = v1 * v1 * p3;
        p  = v1 * p2;
        v1 = asr64(w, 8) + (p << 12);
        w  = (ONE_Q47 + v1) * p1;
        v1 = asr64(w, 33);

        if (v1 == 64'd0) begin
            press = 64'd0;
        end else begin
            p  = 64'd1048576 - {44'd0, raw_p};
            w  = ((p << 31) - v2) * 64'd3125;
            p  = sdiv64(w, v1);
            w  = p9 * asr64(p, 13) * asr64(p, 13);
            v1 = asr64(w, 25);
            w  = p8 * p;
            v2 = asr64(w, 19);
            w  = p + v1 + v2;
            p  = asr64(w, 8) + (p7 << 4);
            if (p[63])
                press = 64'd0;
            else if (p > {32'd0, PRESS_MAX})
                press = {32'd0, PRESS_MAX};
            else
                press = p;
        end
        r.temp_centi  = temp;
        r.press_q24_8 = press[31:0];
        r.sample_ok   = (press != 64'd0);
        return r;
    endfunction

    assign o_pending = comp_expect.size();

    always @(posedge i_clk) begin
        comp_result_t e;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (cal_q[i]) cal_q[i] <= '0;
            comp_expect.delete();
            o_fail_count <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                comp_expect.push_back(compensate(in_ch.raw_temp, in_ch.raw_press));
            if (out_ch.valid && out_ch.ready) begin
                if (comp_expect.size() == 0) begin
                    $error("result with no request outstanding");
                    errs++;
                end else begin
                    e = comp_expect.pop_front();
                    if (out_ch.temp_centi !== e.temp_centi) begin
                        $error("temp_centi: expected %0d, got %0d", e.temp_centi,
                               out_ch.temp_centi);
                        errs++;
                    end
                    if (out_ch.press_q24_8 !== e.press_q24_8) begin
                        $error("press_q24_8: expected %0d, got %0d", e.press_q24_8,
                               out_ch.press_q24_8);
                        errs++;
                    end
                    if (out_ch.sample_ok !== e.sample_ok) begin
                        $error("sample_ok: expected %0b, got %0b", e.sample_ok,
                               out_ch.sample_ok);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            // prediction above uses the settings in force before this write
            if (i_cfg_we && i_cfg_idx < NUM_CAL)
                cal_q[i_cfg_idx] <= i_cfg_data;
        end
    end
endmodule

[bench/pressure_temperature_compensation_tb.sv]
`timescale 1ns / 100ps

module pressure_temperature_compensation_tb;
    import ptc_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CAL_IDX_W-1:0] i_cfg_idx;
    logic [CAL_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   pending;
    int                   stall_mode;
    int                   stall_tick;

    ptc_in_if  in_ch ();
    ptc_out_if out_ch ();

    pressure_temperature_compensation DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ptc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // receiver stall pattern, changed per phase
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= (stall_tick % 7 != 3) && (stall_tick % 11 != 5);
            end
            2: begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_ch.ready <= ((stall_tick / 40) % 2 == 0) || (stall_tick % 3 == 0);
            end
        endcase
    end

    task automatic send_sample(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
        logic rdy;
        in_ch.valid     <= 1'b1;
        in_ch.raw_temp  <= raw_t;
        in_ch.raw_press <= raw_p;
        forever begin
            @(negedge i_clk);
            rdy = in_ch.ready;
            @(posedge i_clk);
            if (rdy)
                break;
        end
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every result is back, then let the pipeline drain
    task automatic drain();
        idle_gap(1);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cal(logic [CAL_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_cal(logic [CAL_W-1:0] c0, logic [CAL_W-1:0] c1,
                            logic [CAL_W-1:0] c2, logic [CAL_W-1:0] c3);
        drain();
        write_cal(CAL_TEMP, c0);
        write_cal(CAL_PRESS_A, c1);
        write_cal(CAL_PRESS_B, c2);
        write_cal(CAL_PRESS_C, c3);
    endtask

    function automatic logic [CAL_W-1:0] rand_cal();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    task automatic random_burst(int count, bit near_typical);
        int burst;
        logic [RAW_W-1:0] t, p;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (near_typical && $urandom_range(0, 1)) begin
                t = 20'($urandom_range(380000, 620000));
                p = 20'($urandom_range(200000, 500000));
            end else begin
                t = 20'($urandom());
                p = 20'($urandom());
            end
            send_sample(t, p);
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0)
                    idle_gap($urandom_range(1, 8));
            end else begin
                burst--;
            end
        end
    endtask

    localparam logic [CAL_W-1:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [CAL_W-1:0] TYP_PA   = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [CAL_W-1:0] TYP_PB   = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [CAL_W-1:0] TYP_PC   = {16'd6000, 16'hC6F8, 16'd15500};

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.raw_temp  = '0;
        in_ch.raw_press = '0;
        out_ch.ready    = 1'b0;
        stall_mode      = 0;
        stall_tick      = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared calibration: zero divisor
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h7EED0, 20'h655AC);

        load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'h00000);
        send_sample(20'h80000, 20'h80000);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'hAAAAA, 20'h55555);
        send_sample(20'd440000, 20'd300000);
        send_sample(20'd600000, 20'd500000);

        // negative pressure: large positive offset pushes numerator below zero
        load_cal(TYP_TEMP, TYP_PA, {16'hFFF9, 16'd140, 16'h7FFF}, TYP_PC);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'hFFFFF, 20'hFFFFF);
        // saturation: huge P7 offset and small divisor
        load_cal(TYP_TEMP, {16'd0, 16'd0, 16'd1}, {16'd0, 16'd0, 16'h8000},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_sample(20'd519888, 20'h00000);
        send_sample(20'h00000, 20'h00000);
        // all-ones and most-negative coefficient sets
        load_cal({CAL_W{1'b1}}, {CAL_W{1'b1}}, {CAL_W{1'b1}}, {CAL_W{1'b1}});
        send_sample(20'hFFFFF, 20'h00000);
        send_sample(20'h00000, 20'hFFFFF);
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                 {3{16'h8000}}, {3{16'h8000}});
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h00000, 20'h00000);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC);
                1: load_cal(TYP_TEMP ^ ($urandom() & 32'h00FF00FF),
                            TYP_PA ^ ($urandom() & 32'h00FF00FF),
                            TYP_PB ^ ($urandom() & 32'h000F000F), TYP_PC);
                2: load_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
                default: load_cal({CAL_W{1'b1}}, rand_cal(), {3{16'h7FFF}}, {3{16'h8000}});
            endcase
            stall_mode = ph % 4;
            random_burst(165, (ph % 4) < 2);
        end

        idle_gap(1);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
